[src/wdcl_pkg.sv]
// ----------------------------------------------------------------------------
// wdcl_pkg
// Shared types and constants of the WAV data chunk locator.
// ----------------------------------------------------------------------------
package wdcl_pkg;

    localparam int unsigned MAX_BYTES = 1048576;
    localparam int unsigned MIN_LEN   = 44;
    localparam int unsigned WALK_BASE = 12;
    localparam int unsigned HDR_LEN   = 8;

    localparam int unsigned COUNT_W  = $clog2(MAX_BYTES + 1);
    localparam int unsigned CHUNK_W  = 34;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OFFSET_W = 21;
    localparam int unsigned SAMPLE_W = 31;
    localparam int unsigned WORD32_W = 32;

    localparam logic [WORD32_W-1:0] ID_RIFF = 32'h5249_4646;
    localparam logic [WORD32_W-1:0] ID_WAVE = 32'h5741_5645;
    localparam logic [WORD32_W-1:0] ID_DATA = 32'h6461_7461;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RIFF   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_WAVE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_DATA   = 3'd4;

    typedef enum logic [1:0] {
        PH_SIG,
        PH_WALK,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic              fire;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } step_t;

    typedef struct packed {
        logic                emit;
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] pcm_offset;
        logic [SAMPLE_W-1:0] sample_count;
    } result_t;

    function automatic logic [BYTE_W-1:0] id_byte(
        input logic [WORD32_W-1:0] id,
        input logic [1:0]          idx
    );
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = id[31:24];
            2'd1:    b = id[23:16];
            2'd2:    b = id[15:8];
            default: b = id[7:0];
        endcase
        return b;
    endfunction

endpackage

[src/wdcl_byte_if.sv]
// ----------------------------------------------------------------------------
// wdcl_byte_if
// Byte stream channel: one buffer byte per word, flag on the final byte.
// ----------------------------------------------------------------------------
interface wdcl_byte_if;

    logic                      valid;
    logic                      ready;
    logic [wdcl_pkg::BYTE_W-1:0] data_byte;
    logic                      last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

[src/wdcl_status_if.sv]
// ----------------------------------------------------------------------------
// wdcl_status_if
// Status channel: one word per buffer with the data chunk location.
// ----------------------------------------------------------------------------
interface wdcl_status_if;

    logic                          valid;
    logic                          ready;
    logic [wdcl_pkg::STATUS_W-1:0] status;
    logic [wdcl_pkg::OFFSET_W-1:0] pcm_offset;
    logic [wdcl_pkg::SAMPLE_W-1:0] sample_count;

    modport source (output valid, output status, output pcm_offset,
                    output sample_count, input ready);
    modport sink   (input valid, input status, input pcm_offset,
                    input sample_count, output ready);

endinterface

[src/wdcl_parser.sv]
// ----------------------------------------------------------------------------
// wdcl_parser
// Parser state and per-byte update: signature check, chunk walk, decision.
// ----------------------------------------------------------------------------
module wdcl_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  wdcl_pkg::step_t   step,
    output wdcl_pkg::result_t res
);

    logic [wdcl_pkg::COUNT_W-1:0]  pos_reg,       pos_next;
    logic [wdcl_pkg::CHUNK_W-1:0]  ncs_reg,       ncs_next;
    logic [wdcl_pkg::WORD32_W-1:0] id_reg,        id_next;
    logic [wdcl_pkg::WORD32_W-1:0] size_reg,      size_next;
    wdcl_pkg::phase_t              phase_reg,     phase_next;
    logic [wdcl_pkg::STATUS_W-1:0] pend_reg,      pend_next;
    logic [wdcl_pkg::OFFSET_W-1:0] found_off_reg, found_off_next;
    logic [wdcl_pkg::SAMPLE_W-1:0] found_smp_reg, found_smp_next;
    logic                          sent_reg,      sent_next;

    logic [wdcl_pkg::COUNT_W-1:0]  count;
    logic [wdcl_pkg::CHUNK_W-1:0]  pos_ext;
    logic [wdcl_pkg::CHUNK_W-1:0]  rel;
    logic [wdcl_pkg::WORD32_W-1:0] size_new;
    logic [wdcl_pkg::STATUS_W-1:0] st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ncs_reg       <= wdcl_pkg::CHUNK_W'(wdcl_pkg::WALK_BASE);
            id_reg        <= '0;
            size_reg      <= '0;
            phase_reg     <= wdcl_pkg::PH_SIG;
            pend_reg      <= wdcl_pkg::ST_FOUND;
            found_off_reg <= '0;
            found_smp_reg <= '0;
            sent_reg      <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            ncs_reg       <= ncs_next;
            id_reg        <= id_next;
            size_reg      <= size_next;
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            found_off_reg <= found_off_next;
            found_smp_reg <= found_smp_next;
            sent_reg      <= sent_next;
        end
    end

    assign count    = pos_reg + 1'b1;
    assign pos_ext  = {{(wdcl_pkg::CHUNK_W - wdcl_pkg::COUNT_W){1'b0}}, pos_reg};
    assign rel      = pos_ext - ncs_reg;
    assign size_new = {step.data_byte, size_reg[wdcl_pkg::WORD32_W-1:wdcl_pkg::BYTE_W]};

    always_comb
    begin
        pos_next       = pos_reg;
        ncs_next       = ncs_reg;
        id_next        = id_reg;
        size_next      = size_reg;
        phase_next     = phase_reg;
        pend_next      = pend_reg;
        found_off_next = found_off_reg;
        found_smp_next = found_smp_reg;
        sent_next      = sent_reg;
        st             = pend_reg;
        res            = '0;

        if (step.fire && !sent_reg)
        begin
            case (phase_reg)
                wdcl_pkg::PH_SIG:
                begin
                    if (pos_reg < wdcl_pkg::COUNT_W'(4))
                    begin
                        if (step.data_byte != wdcl_pkg::id_byte(wdcl_pkg::ID_RIFF, pos_reg[1:0]))
                        begin
                            phase_next = wdcl_pkg::PH_DONE;
                            pend_next  = wdcl_pkg::ST_NO_RIFF;
                        end
                    end
                    else if (pos_reg >= wdcl_pkg::COUNT_W'(8) &&
                             pos_reg < wdcl_pkg::COUNT_W'(wdcl_pkg::WALK_BASE))
                    begin
                        if (step.data_byte != wdcl_pkg::id_byte(wdcl_pkg::ID_WAVE, pos_reg[1:0]))
                        begin
                            phase_next = wdcl_pkg::PH_DONE;
                            pend_next  = wdcl_pkg::ST_NO_WAVE;
                        end
                        else if (pos_reg == wdcl_pkg::COUNT_W'(wdcl_pkg::WALK_BASE - 1))
                        begin
                            phase_next = wdcl_pkg::PH_WALK;
                        end
                    end
                end
                wdcl_pkg::PH_WALK:
                begin
                    if (pos_ext >= ncs_reg && rel < wdcl_pkg::CHUNK_W'(wdcl_pkg::HDR_LEN))
                    begin
                        if (!rel[2])
                        begin
                            id_next = {id_reg[wdcl_pkg::WORD32_W-wdcl_pkg::BYTE_W-1:0],
                                       step.data_byte};
                        end
                        else
                        begin
                            size_next = size_new;
                            if (rel[1:0] == 2'd3)
                            begin
                                if (id_reg == wdcl_pkg::ID_DATA)
                                begin
                                    found_off_next = ncs_reg[wdcl_pkg::OFFSET_W-1:0] +
                                                     wdcl_pkg::OFFSET_W'(wdcl_pkg::HDR_LEN);
                                    found_smp_next = size_new[wdcl_pkg::WORD32_W-1:1];
                                    phase_next     = wdcl_pkg::PH_DONE;
                                    pend_next      = wdcl_pkg::ST_FOUND;
                                end
                                else
                                begin
                                    ncs_next = ncs_reg +
                                               wdcl_pkg::CHUNK_W'(wdcl_pkg::HDR_LEN) +
                                               wdcl_pkg::CHUNK_W'(size_new) +
                                               wdcl_pkg::CHUNK_W'(size_new[0]);
                                end
                                id_next   = '0;
                                size_next = '0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            pos_next = count;
            if (phase_next != wdcl_pkg::PH_DONE &&
                count >= wdcl_pkg::COUNT_W'(wdcl_pkg::MAX_BYTES))
            begin
                phase_next = wdcl_pkg::PH_DONE;
                pend_next  = wdcl_pkg::ST_NO_DATA;
            end

            st = pend_next;
            if (step.last_byte)
            begin
                res.emit = 1'b1;
                if (count < wdcl_pkg::COUNT_W'(wdcl_pkg::MIN_LEN))
                begin
                    st = wdcl_pkg::ST_TOO_SHORT;
                end
                else if (phase_next != wdcl_pkg::PH_DONE)
                begin
                    st = wdcl_pkg::ST_NO_DATA;
                end
            end
            else if (phase_next == wdcl_pkg::PH_DONE &&
                     count >= wdcl_pkg::COUNT_W'(wdcl_pkg::MIN_LEN))
            begin
                res.emit  = 1'b1;
                sent_next = 1'b1;
            end

            res.status = st;
            if (st == wdcl_pkg::ST_FOUND)
            begin
                res.pcm_offset   = found_off_next;
                res.sample_count = found_smp_next;
            end
        end

        // rearm on the final byte
        if (step.fire && step.last_byte)
        begin
            pos_next       = '0;
            ncs_next       = wdcl_pkg::CHUNK_W'(wdcl_pkg::WALK_BASE);
            id_next        = '0;
            size_next      = '0;
            phase_next     = wdcl_pkg::PH_SIG;
            pend_next      = wdcl_pkg::ST_FOUND;
            found_off_next = '0;
            found_smp_next = '0;
            sent_next      = 1'b0;
        end
    end

endmodule

[src/wav_data_chunk_locator_unit.sv]
// ----------------------------------------------------------------------------
// wav_data_chunk_locator_unit
// Streaming RIFF/WAVE parser that locates the data chunk of each buffer.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | words
//  stream  | in  | data_byte[7:0], last_byte                | one per byte
//  report  | out | status[2:0], pcm_offset[20:0],           | one per buffer
//          |     | sample_count[30:0]                       |
//
//  One byte a cycle unless a held report stalls the parser; a word goes
//  through an input register, the parser update and the report register.
//  The parser state updates once per accepted byte (one 34-bit
//  compare and add on the chunk offset).
//  Reset clears the parser to the start of a buffer.
//  A held report stalls the parser only when a byte waits on it.
// ----------------------------------------------------------------------------
module wav_data_chunk_locator_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    wdcl_byte_if.sink            stream,
    wdcl_status_if.source        report
);

    logic                          in_vld_reg,    in_vld_next;
    logic [wdcl_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          in_last_reg;
    logic                          out_vld_reg,   out_vld_next;
    logic [wdcl_pkg::STATUS_W-1:0] out_status_reg;
    logic [wdcl_pkg::OFFSET_W-1:0] out_offset_reg;
    logic [wdcl_pkg::SAMPLE_W-1:0] out_count_reg;

    logic              advance;
    logic              take;
    wdcl_pkg::step_t   step;
    wdcl_pkg::result_t res;

    assign advance      = in_vld_reg && (!out_vld_reg || report.ready);
    assign stream.ready = !in_vld_reg || advance;
    assign take         = stream.valid && stream.ready;

    assign step.fire      = advance;
    assign step.data_byte = in_byte_reg;
    assign step.last_byte = in_last_reg;

    wdcl_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .res   (res)
    );

    always_comb
    begin
        in_vld_next = take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        if (advance && res.emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (report.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= stream.data_byte;
            in_last_reg <= stream.last_byte;
        end
        if (advance && res.emit)
        begin
            out_status_reg <= res.status;
            out_offset_reg <= res.pcm_offset;
            out_count_reg  <= res.sample_count;
        end
    end

    assign report.valid        = out_vld_reg;
    assign report.status       = out_status_reg;
    assign report.pcm_offset   = out_offset_reg;
    assign report.sample_count = out_count_reg;

endmodule

[src/wdcl_checker.sv]
// ----------------------------------------------------------------------------
// wdcl_checker
// Port-level checks on the report channel of the chunk locator.
// ----------------------------------------------------------------------------
module wdcl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [wdcl_pkg::STATUS_W-1:0] status,
    input logic [wdcl_pkg::OFFSET_W-1:0] pcm_offset,
    input logic [wdcl_pkg::SAMPLE_W-1:0] sample_count
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(pcm_offset) && $stable(sample_count))
        else $error("report word changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= wdcl_pkg::ST_NO_DATA)
        else $error("status code out of range");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != wdcl_pkg::ST_FOUND |->
        pcm_offset == '0 && sample_count == '0)
        else $error("location reported on a failed buffer");

    a_found_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == wdcl_pkg::ST_FOUND |->
        pcm_offset >= wdcl_pkg::OFFSET_W'(wdcl_pkg::WALK_BASE + wdcl_pkg::HDR_LEN))
        else $error("data payload offset before first chunk body");

endmodule

bind wav_data_chunk_locator_unit wdcl_checker u_wdcl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (report.valid),
    .out_ready    (report.ready),
    .status       (report.status),
    .pcm_offset   (report.pcm_offset),
    .sample_count (report.sample_count)
);

[tb/tb_wav_data_chunk_locator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_data_chunk_locator_unit
// Streams whole buffers into the locator and checks one report per buffer.
// Buffers include well-formed RIFF/WAVE images with random chunk lists, broken
// signatures, cut headers, short buffers and noise. A byte-level parser model
// tracks every accepted word and queues the report it predicts. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_wav_data_chunk_locator_unit;

    import wdcl_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0]  pos;
        logic [CHUNK_W-1:0]  chunk_at;
        logic [WORD32_W-1:0] id_acc;
        logic [WORD32_W-1:0] size_acc;
        phase_t              phase;
        logic [STATUS_W-1:0] pend;
        logic [OFFSET_W-1:0] off;
        logic [SAMPLE_W-1:0] samples;
        logic                sent;
    } parser_t;

    typedef struct {
        logic [BYTE_W-1:0] b;
        logic              last;
        int unsigned       gap;
        bit                drain;
    } word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wdcl_byte_if   stream ();
    wdcl_status_if report ();

    wav_data_chunk_locator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .report (report)
    );

    always #1 clk = ~clk;

    word_t             byte_words[$];
    result_t           expected_reports[$];
    logic [BYTE_W-1:0] frame[$];

    parser_t     live_parse;
    int unsigned words_total  = 0;
    int unsigned words_in     = 0;
    int unsigned buffers      = 0;
    int unsigned reports_seen = 0;
    int unsigned fail_cnt     = 0;
    int unsigned data_at      = 0;
    bit          tx_calm      = 1'b0;

    word_t       next_w;
    bit          have_next = 1'b0;
    int unsigned hold_cnt  = 0;
    int unsigned stall_cnt = 0;
    bit          rx_calm   = 1'b0;

    function automatic parser_t parser_idle();
        parser_t s;
        s          = '0;
        s.chunk_at = WALK_BASE;
        s.phase    = PH_SIG;
        return s;
    endfunction

    task automatic parse_byte(inout parser_t s, input logic [BYTE_W-1:0] b,
                              input logic fin, output result_t r);
        logic [CHUNK_W-1:0]  p_wide;
        logic [CHUNK_W-1:0]  rel;
        logic [CHUNK_W-1:0]  size_wide;
        logic [CHUNK_W-1:0]  payload_at;
        logic [COUNT_W-1:0]  cnt;
        logic [STATUS_W-1:0] st;
        logic                fire_now;
        r = '0;
        if (s.sent) begin
            if (fin)
                s = parser_idle();
        end
        else begin
            p_wide = s.pos;
            if (s.phase == PH_SIG) begin
                if (s.pos < 4) begin
                    if (b != ID_RIFF[8 * (3 - s.pos[1:0]) +: 8]) begin
                        s.phase = PH_DONE;
                        s.pend  = ST_NO_RIFF;
                    end
                end
                else if (s.pos >= 8 && s.pos < 12) begin
                    if (b != ID_WAVE[8 * (3 - s.pos[1:0]) +: 8]) begin
                        s.phase = PH_DONE;
                        s.pend  = ST_NO_WAVE;
                    end
                    else if (s.pos == 11)
                        s.phase = PH_WALK;
                end
            end
            else if (s.phase == PH_WALK && p_wide >= s.chunk_at) begin
                rel = p_wide - s.chunk_at;
                if (rel < 4)
                    s.id_acc = {s.id_acc[23:0], b};
                else if (rel < 8) begin
                    s.size_acc = {b, s.size_acc[31:8]};
                    if (rel == 7) begin
                        if (s.id_acc == ID_DATA) begin
                            payload_at = s.chunk_at + HDR_LEN;
                            s.off      = payload_at[OFFSET_W-1:0];
                            s.samples  = s.size_acc[31:1];
                            s.phase    = PH_DONE;
                            s.pend     = ST_FOUND;
                        end
                        else begin
                            size_wide  = s.size_acc;
                            s.chunk_at = s.chunk_at + HDR_LEN + size_wide + s.size_acc[0];
                        end
                        s.id_acc   = '0;
                        s.size_acc = '0;
                    end
                end
            end
            cnt   = s.pos + 1'b1;
            s.pos = cnt;
            if (s.phase != PH_DONE && cnt >= MAX_BYTES) begin
                s.phase = PH_DONE;
                s.pend  = ST_NO_DATA;
            end
            st       = s.pend;
            fire_now = 1'b0;
            if (fin) begin
                fire_now = 1'b1;
                if (cnt < MIN_LEN)
                    st = ST_TOO_SHORT;
                else if (s.phase != PH_DONE)
                    st = ST_NO_DATA;
            end
            else if (s.phase == PH_DONE && cnt >= MIN_LEN)
                fire_now = 1'b1;
            if (fire_now) begin
                r.emit   = 1'b1;
                r.status = st;
                if (st == ST_FOUND) begin
                    r.pcm_offset   = s.off;
                    r.sample_count = s.samples;
                end
            end
            if (fin)
                s = parser_idle();
            else if (fire_now)
                s.sent = 1'b1;
        end
    endtask

    function automatic int unsigned idle_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    endfunction

    function automatic int unsigned tx_gap();
        if (tx_calm || $urandom_range(0, 99) < 70)
            return 0;
        return idle_len();
    endfunction

    task automatic put_id(input logic [WORD32_W-1:0] id);
        frame.push_back(id[31:24]);
        frame.push_back(id[23:16]);
        frame.push_back(id[15:8]);
        frame.push_back(id[7:0]);
    endtask

    task automatic put_le32(input logic [WORD32_W-1:0] v);
        frame.push_back(v[7:0]);
        frame.push_back(v[15:8]);
        frame.push_back(v[23:16]);
        frame.push_back(v[31:24]);
    endtask

    task automatic put_rand(input int unsigned n);
        repeat (n) frame.push_back($urandom_range(0, 255));
    endtask

    task automatic put_fill(input int unsigned n, input logic [BYTE_W-1:0] v);
        repeat (n) frame.push_back(v);
    endtask

    task automatic cut_frame(input int unsigned len);
        while (frame.size() > len && frame.size() > 1)
            void'(frame.pop_back());
    endtask

    task automatic send_frame(input bit paced, input bit drain_first);
        word_t w;
        for (int unsigned i = 0; i < frame.size(); i++) begin
            w.b     = frame[i];
            w.last  = (i == frame.size() - 1);
            w.gap   = paced ? tx_gap() : 0;
            w.drain = drain_first && (i == 0);
            byte_words.push_back(w);
            words_total++;
        end
        frame.delete();
        buffers++;
    endtask

    task automatic build_wav(input bit with_data);
        int unsigned       n;
        int unsigned       body;
        logic [WORD32_W-1:0] size;
        put_id(ID_RIFF);
        put_le32($urandom);
        put_id(ID_WAVE);
        n = $urandom_range(0, 3);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                put_id(ID_DATA ^ (32'd1 << $urandom_range(0, 31)));
            else
                put_id($urandom);
            size = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 13);
            put_le32(size);
            body = (size <= 13) ? size + size[0] : $urandom_range(0, 8);
            put_rand(body);
        end
        data_at = frame.size();
        if (with_data) begin
            put_id(ID_DATA);
            case ($urandom_range(0, 3))
                0:       put_le32($urandom_range(0, 64));
                1:       put_le32(32'hFFFF_FFFF - $urandom_range(0, 1));
                default: put_le32($urandom);
            endcase
        end
        put_rand((frame.size() < MIN_LEN ? MIN_LEN - frame.size() : 0) + $urandom_range(0, 6));
    endtask

    // driver: feed byte words, apply gaps and drain holds
    always @(posedge clk or negedge rst_n) begin
        result_t r;
        if (!rst_n) begin
            stream.valid     <= 1'b0;
            stream.data_byte <= '0;
            stream.last_byte <= 1'b0;
        end
        else begin
            if (stream.valid && stream.ready) begin
                parse_byte(live_parse, stream.data_byte, stream.last_byte, r);
                if (r.emit)
                    expected_reports.push_back(r);
                words_in++;
            end
            if (!stream.valid || stream.ready) begin
                if (!have_next && byte_words.size() != 0) begin
                    next_w    = byte_words.pop_front();
                    have_next = 1'b1;
                    hold_cnt  = next_w.gap;
                end
                if (have_next && hold_cnt == 0
                    && !(next_w.drain && expected_reports.size() != 0)) begin
                    stream.valid     <= 1'b1;
                    stream.data_byte <= next_w.b;
                    stream.last_byte <= next_w.last;
                    have_next = 1'b0;
                end
                else begin
                    if (hold_cnt != 0)
                        hold_cnt--;
                    stream.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check reports, stall the report channel
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n)
            report.ready <= 1'b0;
        else begin
            if (report.valid && report.ready) begin
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected report: status %0d pcm_offset 0x%0h sample_count 0x%0h",
                           report.status, report.pcm_offset, report.sample_count);
                    fail_cnt++;
                end
                else begin
                    want = expected_reports.pop_front();
                    if (report.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, report.status);
                        fail_cnt++;
                    end
                    if (report.pcm_offset !== want.pcm_offset) begin
                        $error("pcm_offset: expected 0x%0h, actual 0x%0h",
                               want.pcm_offset, report.pcm_offset);
                        fail_cnt++;
                    end
                    if (report.sample_count !== want.sample_count) begin
                        $error("sample_count: expected 0x%0h, actual 0x%0h",
                               want.sample_count, report.sample_count);
                        fail_cnt++;
                    end
                end
            end
            if ($urandom_range(0, 299) == 0)
                rx_calm = !rx_calm;
            if (stall_cnt != 0) begin
                stall_cnt--;
                report.ready <= 1'b0;
            end
            else if (!rx_calm && $urandom_range(0, 99) < 25) begin
                stall_cnt = idle_len() - 1;
                report.ready <= 1'b0;
            end
            else
                report.ready <= 1'b1;
        end
    end

    initial begin
        int unsigned mode;
        int unsigned idx;
        stream.valid     = 1'b0;
        stream.data_byte = '0;
        stream.last_byte = 1'b0;
        report.ready     = 1'b0;
        live_parse       = parser_idle();

        // found right after WAVE, held until byte 44
        put_id(ID_RIFF); put_le32(32'd36); put_id(ID_WAVE);
        put_id(ID_DATA); put_le32(32'd0); put_fill(MIN_LEN - 20, 8'h00);
        send_frame(1'b1, 1'b0);
        // odd chunk with pad, largest size, report before the end
        put_id(ID_RIFF); put_le32(32'hFFFF_FFFF); put_id(ID_WAVE);
        put_id(32'h666D_7420); put_le32(32'd16); put_fill(16, 8'hFF);
        put_id(32'h4C49_5354); put_le32(32'd3); put_rand(4);
        put_id(ID_DATA); put_le32(32'hFFFF_FFFF); put_rand(10);
        send_frame(1'b1, 1'b1);
        // single byte, short with a bad signature, one byte short
        put_id(ID_RIFF); cut_frame(1);
        send_frame(1'b1, 1'b0);
        put_id(32'h5249_4658); put_rand(15);
        send_frame(1'b1, 1'b0);
        put_id(ID_RIFF); put_le32(32'd0); put_id(ID_WAVE); put_id(ID_DATA);
        put_le32(32'd8); put_rand(MIN_LEN - 1 - 20);
        send_frame(1'b1, 1'b0);
        // bad RIFF, bad WAVE
        put_id(32'h7249_4646); put_rand(46);
        send_frame(1'b1, 1'b0);
        put_id(ID_RIFF); put_le32($urandom); put_id(32'h5741_5646); put_rand(40);
        send_frame(1'b1, 1'b0);
        // no data chunk: near-miss id and a chunk that runs past the end
        put_id(ID_RIFF); put_le32($urandom); put_id(ID_WAVE);
        put_id(32'h6461_7462); put_le32(32'd16); put_rand(16);
        put_id(32'h6A75_6E6B); put_le32(32'hFFFF_FFFF); put_rand(20);
        send_frame(1'b1, 1'b0);
        // data header cut by one byte, then complete on the last byte
        put_id(ID_RIFF); put_le32($urandom); put_id(ID_WAVE);
        put_id(32'h666D_7420); put_le32(32'd24); put_rand(24);
        put_id(ID_DATA); put_rand(3);
        send_frame(1'b1, 1'b0);
        put_id(ID_RIFF); put_le32($urandom); put_id(ID_WAVE);
        put_id(32'h666D_7420); put_le32(32'd24); put_rand(24);
        put_id(ID_DATA); put_le32(32'h0000_1235);
        send_frame(1'b1, 1'b0);
        // header ends exactly at byte 44, which is the last byte
        put_id(ID_RIFF); put_le32($urandom); put_id(ID_WAVE);
        put_id(32'h666D_7420); put_le32(32'd16); put_rand(16);
        put_id(ID_DATA); put_le32(32'h8000_0001);
        send_frame(1'b1, 1'b0);
        // all zeros, all ones
        put_fill(60, 8'h00);
        send_frame(1'b1, 1'b0);
        put_fill(48, 8'hFF);
        send_frame(1'b1, 1'b0);

        while (words_total < 1250) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            mode    = $urandom_range(0, 99);
            if (mode < 50)
                build_wav($urandom_range(0, 6) != 0);
            else if (mode < 62) begin
                build_wav(1'b1);
                idx = $urandom_range(0, 7);
                idx = (idx < 4) ? idx : idx + 4;
                frame[idx] = frame[idx] ^ $urandom_range(1, 255);
            end
            else if (mode < 72)
                put_rand($urandom_range(1, 70));
            else if (mode < 82) begin
                build_wav(1'b1);
                cut_frame($urandom_range(1, MIN_LEN - 1));
            end
            else if (mode < 92) begin
                build_wav(1'b1);
                cut_frame(data_at + $urandom_range(1, 8));
            end
            else begin
                build_wav(1'b1);
                cut_frame($urandom_range(1, frame.size()));
            end
            send_frame(1'b1, $urandom_range(0, 19) == 0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (words_in != words_total)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d buffers: good, cut, corrupted and noise", buffers);
        $display("%0d words accepted, %0d reports checked, %0d mismatches",
                 words_in, reports_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("wav_data_chunk_locator_unit test passed");
        else
            $display("wav_data_chunk_locator_unit test failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("wav_data_chunk_locator_unit test failed");
        $finish;
    end

endmodule
